@@ hw/rtl/dsvb_pkg.sv @@
package dsvb_pkg;

    localparam int VOICES_DEFAULT     = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int PHASE_W = 24;
    localparam int LEVEL_W = 17;
    localparam int DECAY_W = 17;
    localparam int SINE_W  = 15;
    localparam int MIX_W   = 20;
    localparam int PROD_W  = LEVEL_W + LEVEL_W;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(65536);
    localparam int MIX_MAX = 524287;
    localparam int MIX_MIN = -524288;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic              neg;
        logic [SINE_W-1:0] mag;
    } sine_t;

    // sin of a first-quadrant angle in Q30 radians, Taylor series through x^11, Q15 out
    function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] rnd;
        begin
            x2   = (x * x) >> 30;
            sum  = $signed(x);
            term = ((x * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            if (sum < 0)
            begin
                sum = 0;
            end
            rnd = (sum + 64'sd16384) >>> 15;
            if (rnd > 64'sd32767)
            begin
                rnd = 64'sd32767;
            end
            return rnd[SINE_W-1:0];
        end
    endfunction

    function automatic logic [SINE_W-1:0] quarter_entry(input int r, input int qbits);
        logic [63:0] ang;
        begin
            ang = (64'(r) * HALF_PI_Q30) >> qbits;
            return quarter_sine(ang);
        end
    endfunction

endpackage

@@ hw/rtl/dsvb_in_if.sv @@
interface dsvb_in_if;
    import dsvb_pkg::*;

    logic               valid;
    logic               ready;
    logic               start_voice;
    logic [PHASE_W-1:0] start_step;
    logic [DECAY_W-1:0] decay_factor;

    modport source (output valid, output start_voice, output start_step,
                    output decay_factor, input ready);
    modport sink   (input valid, input start_voice, input start_step,
                    input decay_factor, output ready);
endinterface

@@ hw/rtl/dsvb_out_if.sv @@
interface dsvb_out_if;
    import dsvb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [MIX_W-1:0] mix_sample;

    modport source (output valid, output mix_sample, input ready);
    modport sink   (input valid, input mix_sample, output ready);
endinterface

@@ hw/rtl/dsvb_sine.sv @@
module dsvb_sine #(
    parameter int SINE_TABLE_BITS = dsvb_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic [dsvb_pkg::PHASE_W-1:0] phase,
    output dsvb_pkg::sine_t              sine
);
    import dsvb_pkg::*;

    localparam int QBITS = SINE_TABLE_BITS - 2;
    localparam int QN    = 1 << QBITS;

    logic [SINE_W-1:0] qtab [QN+1];

    for (genvar k = 0; k <= QN; k++)
    begin : g_tab
        localparam logic [SINE_W-1:0] ENTRY = quarter_entry(k, QBITS);
        assign qtab[k] = ENTRY;
    end

    logic [SINE_TABLE_BITS-1:0] tab_idx;
    logic [1:0]                 quad;
    logic [QBITS:0]             r_idx;
    logic [SINE_W-1:0]          sine_mag_reg;
    logic                       sine_neg_reg;

    assign tab_idx = phase[PHASE_W-1 -: SINE_TABLE_BITS];
    assign quad    = tab_idx[SINE_TABLE_BITS-1 -: 2];

    always_comb
    begin
        if (quad[0])
        begin
            r_idx = (QBITS+1)'(QN) - {1'b0, tab_idx[QBITS-1:0]};
        end
        else
        begin
            r_idx = {1'b0, tab_idx[QBITS-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sine_mag_reg <= qtab[r_idx];
            sine_neg_reg <= quad[1];
        end
    end

    assign sine.neg = sine_neg_reg;
    assign sine.mag = sine_mag_reg;
endmodule

@@ hw/rtl/decaying_sine_voice_bank.sv @@
// Bank of decaying sine voices, one output sample per input transaction. A transaction may
// start the next voice in round-robin order (new step, level 1.0, phase kept, or cleared if
// the voice was never valid); then all voices are summed and advanced. A single shared 17x17
// multiplier walks the voices one at a time, each through memory read, sine lookup, level
// times sine and level times decay; the result register is loaded once the output side is
// free, and only then can the next transaction be accepted. Input ready is low during that
// sweep. The result register frees the input side while a sample waits.
module decaying_sine_voice_bank #(
    parameter int VOICES          = dsvb_pkg::VOICES_DEFAULT,
    parameter int SINE_TABLE_BITS = dsvb_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dsvb_in_if.sink     sample_in,
    dsvb_out_if.source  sample_out
);
    import dsvb_pkg::*;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int ACC_RAW = LEVEL_W + $clog2(VOICES) + 1;
    localparam int ACC_W   = (ACC_RAW > MIX_W) ? ACC_RAW : MIX_W;
    localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICES - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(MIX_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(MIX_MIN);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_READ  = 7'b0000100,
        S_SINE  = 7'b0001000,
        S_AMP   = 7'b0010000,
        S_DECAY = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [PHASE_W-1:0] phase_mem [VOICES];
    logic [PHASE_W-1:0] step_mem  [VOICES];
    logic [LEVEL_W-1:0] level_mem [VOICES];
    logic [VOICES-1:0]  valid_reg;

    logic [PHASE_W-1:0] phase_rd, step_rd;
    logic [LEVEL_W-1:0] level_rd;
    logic               valid_rd;

    logic [VIDX_W-1:0]  idx_reg, next_voice_reg;
    logic               start_reg;
    logic [PHASE_W-1:0] start_step_reg;
    logic [DECAY_W-1:0] decay_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic               out_valid_reg;
    logic signed [MIX_W-1:0] out_mix_reg;

    logic [PHASE_W-1:0] phase_eff, step_eff;
    logic [LEVEL_W-1:0] level_eff;
    logic [LEVEL_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [LEVEL_W-1:0] contrib;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [MIX_W-1:0] mix_sat;
    logic [DECAY_W-1:0] decay_clamped;
    sine_t              sine;
    logic               accept;
    logic               out_free;

    assign accept   = sample_in.valid && sample_in.ready;
    assign out_free = !out_valid_reg || sample_out.ready;
    assign sample_in.ready = (state_reg == S_IDLE);

    assign decay_clamped = (sample_in.decay_factor > LEVEL_ONE) ? LEVEL_ONE
                                                                 : sample_in.decay_factor;

    assign phase_eff = valid_rd ? phase_rd : '0;
    assign step_eff  = valid_rd ? step_rd  : '0;
    assign level_eff = valid_rd ? level_rd : '0;

    dsvb_sine #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .clk   (clk),
        .load  (state_reg == S_SINE),
        .phase (phase_eff),
        .sine  (sine)
    );

    // shared multiplier: level*sine, then level*decay
    assign mul_b   = (state_reg == S_AMP) ? {{(LEVEL_W-SINE_W){1'b0}}, sine.mag} : decay_reg;
    assign mul_p   = level_eff * mul_b;
    assign contrib = prod_reg[LEVEL_W+15:16];
    assign acc_sum = sine.neg ? (acc_reg - $signed({{(ACC_W-LEVEL_W){1'b0}}, contrib}))
                              : (acc_reg + $signed({{(ACC_W-LEVEL_W){1'b0}}, contrib}));

    always_comb
    begin
        if (acc_reg > SAT_HI)
        begin
            mix_sat = MIX_W'(MIX_MAX);
        end
        else if (acc_reg < SAT_LO)
        begin
            mix_sat = MIX_W'(MIX_MIN);
        end
        else
        begin
            mix_sat = acc_reg[MIX_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_START;
                end
            end
            S_START: state_next = S_READ;
            S_READ:  state_next = S_SINE;
            S_SINE:  state_next = S_AMP;
            S_AMP:   state_next = S_DECAY;
            S_DECAY:
            begin
                state_next = (idx_reg == LAST_VOICE) ? S_OUT : S_READ;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            next_voice_reg <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_START && start_reg)
            begin
                valid_reg[next_voice_reg] <= 1'b1;
                next_voice_reg <= (next_voice_reg == LAST_VOICE) ? '0
                                                                 : next_voice_reg + 1'b1;
            end
            if (state_reg == S_START)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == S_DECAY)
            begin
                valid_reg[idx_reg] <= 1'b1;
                if (idx_reg != LAST_VOICE)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sample_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg      <= sample_in.start_voice;
            start_step_reg <= sample_in.start_step;
            decay_reg      <= decay_clamped;
            acc_reg        <= '0;
        end
        if (state_reg == S_AMP)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_DECAY)
        begin
            acc_reg <= acc_sum;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_mix_reg <= mix_sat;
        end
    end

    // voice memories: one write address, registered read at the sweep index
    always_ff @(posedge clk)
    begin
        if (state_reg == S_START && start_reg)
        begin
            step_mem[next_voice_reg]  <= start_step_reg;
            level_mem[next_voice_reg] <= LEVEL_ONE;
            if (!valid_reg[next_voice_reg])
            begin
                phase_mem[next_voice_reg] <= '0;
            end
        end
        else if (state_reg == S_DECAY)
        begin
            phase_mem[idx_reg] <= phase_eff + step_eff;
            step_mem[idx_reg]  <= step_eff;
            level_mem[idx_reg] <= mul_p[LEVEL_W+15:16];
        end
        phase_rd <= phase_mem[idx_reg];
        step_rd  <= step_mem[idx_reg];
        level_rd <= level_mem[idx_reg];
        valid_rd <= valid_reg[idx_reg];
    end

    assign sample_out.valid      = out_valid_reg;
    assign sample_out.mix_sample = out_mix_reg;
endmodule
